[rtl/core/cubic_hermite_joint_interpolator_unit_macros.svh]
// Assertion macros shared by the interpolator RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CUBIC_HERMITE_JOINT_INTERPOLATOR_UNIT_MACROS_SVH
`define CUBIC_HERMITE_JOINT_INTERPOLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHJI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHJI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/chji_pkg.sv]
`timescale 1ns / 1ps
package chji_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int COEF_MAG_W = PROD_W - FRAC_BITS;
	localparam int ACC_W = PROD_W + 4 - FRAC_BITS;
	localparam int DP_W = DATA_W + 1;
	localparam int FRAC_S = 32;
	localparam int S_W = FRAC_S + 1;
	localparam int NUM_W = DATA_W + S_W;
	localparam int DIV_STEPS = S_W;
	localparam int MAG_W = ACC_W - 1;
	localparam int HI_W = MAG_W - FRAC_S;
	localparam int HI_PROD_W = HI_W + S_W;
	localparam int LO_PROD_W = FRAC_S + S_W;
	localparam int PRE_STAGES = 3;
	localparam int HORNER_STAGES = 4;
	localparam int HORNER_STEPS = 3;
	localparam int LATENCY = PRE_STAGES + DIV_STEPS + HORNER_STEPS * HORNER_STAGES + 1;

	localparam logic [PROD_W-1:0] ROUND_F = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [LO_PROD_W-1:0] ROUND_S = LO_PROD_W'(1) << (FRAC_S - 1);
	localparam logic [S_W-1:0] S_ONE = S_W'(1) << FRAC_S;
	localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SAT      = 2'd1,
		ST_ZERO_DUR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_C2 = 2'd0,
		SEL_A  = 2'd1,
		SEL_P0 = 2'd2
	} coef_sel_t;

	typedef struct packed {
		logic [DATA_W-1:0]        elapsed_time;
		logic [DATA_W-1:0]        segment_duration;
		logic signed [DATA_W-1:0] start_position;
		logic signed [DATA_W-1:0] end_position;
		logic signed [DATA_W-1:0] start_velocity;
		logic signed [DATA_W-1:0] end_velocity;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] position;
		status_t                  status;
	} out_item_t;

	typedef struct packed {
		logic                     zero_dur;
		logic signed [DATA_W-1:0] p0;
		logic signed [ACC_W-1:0]  a;
		logic signed [ACC_W-1:0]  c2;
		logic signed [ACC_W-1:0]  c3;
	} side_t;
endpackage

[rtl/core/cubic_hermite_joint_interpolator_unit.sv]
// Throughput: one item per cycle; busy never rises because every stage advances each cycle.
// Items pass through the 33-stage divider for normalised time and three Horner steps.
// Reset (arst_n low, asynchronous) clears every valid bit; items in flight are dropped.
// The receiver cannot stall, so done is a single-cycle strobe.
`timescale 1ns / 1ps
`include "cubic_hermite_joint_interpolator_unit_macros.svh"
module cubic_hermite_joint_interpolator_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  chji_pkg::in_item_t    item,
	output logic                  done,
	output chji_pkg::out_item_t   result
);
	// Stage 1: clamp the elapsed time and form duration times velocity magnitudes.
	logic                               valid_s1;
	logic [chji_pkg::DATA_W-1:0]        t_s1, dur_s1;
	logic [chji_pkg::PROD_W-1:0]        prod_a_s1, prod_b_s1;
	logic                               neg_a_s1, neg_b_s1, zero_s1;
	logic signed [chji_pkg::DATA_W-1:0] p0_s1, p1_s1;
	logic [chji_pkg::DATA_W-1:0]        t_clamp, v0_raw, v1_raw, v0_mag, v1_mag;

	// Stage 2: round the scaled velocities, form the position difference and build the divider numerator.
	logic                               valid_s2, zero_s2;
	logic [chji_pkg::DATA_W-1:0]        dur_s2;
	logic [chji_pkg::NUM_W-1:0]         num_s2;
	logic signed [chji_pkg::ACC_W-1:0]  a_s2, b_s2;
	logic signed [chji_pkg::DP_W-1:0]   dp_s2;
	logic signed [chji_pkg::DATA_W-1:0] p0_s2;
	logic [chji_pkg::COEF_MAG_W-1:0]    a_mag, b_mag;
	logic signed [chji_pkg::ACC_W-1:0]  a_ext, b_ext;

	// Stage 3: the two higher-order coefficients.
	logic                               valid_s3;
	logic [chji_pkg::DATA_W-1:0]        dur_s3;
	logic [chji_pkg::NUM_W-1:0]         num_s3;
	chji_pkg::side_t                    side_s3;
	logic signed [chji_pkg::ACC_W-1:0]  dp_ext;

	// Divider and Horner chain.
	logic                               div_valid;
	logic [chji_pkg::S_W-1:0]           div_quot;
	chji_pkg::side_t                    div_side;
	logic                               hv1, hv2, hv3;
	logic signed [chji_pkg::ACC_W-1:0]  hacc1, hacc2, hacc3;
	logic [chji_pkg::S_W-1:0]           hs1, hs2, hs3;
	chji_pkg::side_t                    hside1, hside2, hside3;

	// Output register.
	logic                               done_q;
	chji_pkg::out_item_t                result_q;
	logic                               sat_hi, sat_lo;

	assign t_clamp = (item.elapsed_time > item.segment_duration) ? item.segment_duration
	                                                             : item.elapsed_time;
	assign v0_raw  = item.start_velocity;
	assign v1_raw  = item.end_velocity;
	// The most negative velocity still has a correct unsigned magnitude here.
	assign v0_mag  = v0_raw[chji_pkg::DATA_W-1] ? (chji_pkg::DATA_W'(0) - v0_raw) : v0_raw;
	assign v1_mag  = v1_raw[chji_pkg::DATA_W-1] ? (chji_pkg::DATA_W'(0) - v1_raw) : v1_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= hv3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1      <= t_clamp;
		dur_s1    <= item.segment_duration;
		prod_a_s1 <= chji_pkg::PROD_W'(item.segment_duration) * chji_pkg::PROD_W'(v0_mag);
		prod_b_s1 <= chji_pkg::PROD_W'(item.segment_duration) * chji_pkg::PROD_W'(v1_mag);
		neg_a_s1  <= v0_raw[chji_pkg::DATA_W-1];
		neg_b_s1  <= v1_raw[chji_pkg::DATA_W-1];
		zero_s1   <= (item.segment_duration == '0);
		p0_s1     <= item.start_position;
		p1_s1     <= item.end_position;
	end

	// Ties round away from zero because the rounding is applied to the magnitude.
	assign a_mag = chji_pkg::COEF_MAG_W'((prod_a_s1 + chji_pkg::ROUND_F) >> chji_pkg::FRAC_BITS);
	assign b_mag = chji_pkg::COEF_MAG_W'((prod_b_s1 + chji_pkg::ROUND_F) >> chji_pkg::FRAC_BITS);
	assign a_ext = signed'(chji_pkg::ACC_W'(a_mag));
	assign b_ext = signed'(chji_pkg::ACC_W'(b_mag));

	always_ff @(posedge clk) begin
		a_s2    <= neg_a_s1 ? -a_ext : a_ext;
		b_s2    <= neg_b_s1 ? -b_ext : b_ext;
		dp_s2   <= chji_pkg::DP_W'(p1_s1) - chji_pkg::DP_W'(p0_s1);
		// Numerator t * 2^32 + T / 2 gives round-half-up normalised time.
		num_s2  <= chji_pkg::NUM_W'({t_s1, {chji_pkg::FRAC_S{1'b0}}})
		           + chji_pkg::NUM_W'(dur_s1 >> 1);
		dur_s2  <= dur_s1;
		zero_s2 <= zero_s1;
		p0_s2   <= p0_s1;
	end

	assign dp_ext = chji_pkg::ACC_W'(dp_s2);

	always_ff @(posedge clk) begin
		side_s3.zero_dur <= zero_s2;
		side_s3.p0       <= p0_s2;
		side_s3.a        <= a_s2;
		side_s3.c2       <= (dp_ext <<< 1) + dp_ext - (a_s2 <<< 1) - b_s2;
		side_s3.c3       <= a_s2 + b_s2 - (dp_ext <<< 1);
		num_s3           <= num_s2;
		dur_s3           <= dur_s2;
	end

	chji_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.numer     (num_s3),
		.divisor   (dur_s3),
		.side_in   (side_s3),
		.out_valid (div_valid),
		.quot      (div_quot),
		.side_out  (div_side)
	);

	// Horner evaluation in normalised time: ((c3*s + c2)*s + a)*s + p0.
	chji_horner u_horner_c2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.sel       (chji_pkg::SEL_C2),
		.acc_in    (div_side.c3),
		.s_in      (div_quot),
		.side_in   (div_side),
		.out_valid (hv1),
		.acc_out   (hacc1),
		.s_out     (hs1),
		.side_out  (hside1)
	);

	chji_horner u_horner_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hv1),
		.sel       (chji_pkg::SEL_A),
		.acc_in    (hacc1),
		.s_in      (hs1),
		.side_in   (hside1),
		.out_valid (hv2),
		.acc_out   (hacc2),
		.s_out     (hs2),
		.side_out  (hside2)
	);

	chji_horner u_horner_p0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hv2),
		.sel       (chji_pkg::SEL_P0),
		.acc_in    (hacc2),
		.s_in      (hs2),
		.side_out  (hside3),
		.side_in   (hside2),
		.out_valid (hv3),
		.acc_out   (hacc3),
		.s_out     (hs3)
	);

	// The result fits when every bit above the 32-bit sign agrees with it.
	assign sat_hi = !hacc3[chji_pkg::ACC_W-1]
	                && (|hacc3[chji_pkg::ACC_W-2:chji_pkg::DATA_W-1]);
	assign sat_lo = hacc3[chji_pkg::ACC_W-1]
	                && !(&hacc3[chji_pkg::ACC_W-2:chji_pkg::DATA_W-1]);

	always_ff @(posedge clk) begin
		if (hside3.zero_dur) begin
			result_q.position <= hside3.p0;
			result_q.status   <= chji_pkg::ST_ZERO_DUR;
		end else if (sat_hi) begin
			result_q.position <= chji_pkg::POS_MAX;
			result_q.status   <= chji_pkg::ST_SAT;
		end else if (sat_lo) begin
			result_q.position <= chji_pkg::NEG_MIN;
			result_q.status   <= chji_pkg::ST_SAT;
		end else begin
			result_q.position <= hacc3[chji_pkg::DATA_W-1:0];
			result_q.status   <= chji_pkg::ST_OK;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	`CHJI_ASSERT_IMP(a_top_latency, done, $past(start, chji_pkg::LATENCY),
		"result strobed without a matching item")
	`CHJI_ASSERT_IMP(a_top_sat, done && (result.status == chji_pkg::ST_SAT),
		(result.position == chji_pkg::POS_MAX) || (result.position == chji_pkg::NEG_MIN),
		"saturated status without a limit value")
	`CHJI_ASSERT_IMP(a_top_zero, done && (result.status == chji_pkg::ST_ZERO_DUR),
		result.position == $past(item.start_position, chji_pkg::LATENCY),
		"zero duration did not return the start position")
endmodule

[rtl/core/chji_div.sv]
`timescale 1ns / 1ps
`include "cubic_hermite_joint_interpolator_unit_macros.svh"
// Restoring divider, one quotient bit per pipeline stage.
module chji_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [chji_pkg::NUM_W-1:0]        numer,
	input  logic [chji_pkg::DATA_W-1:0]       divisor,
	input  chji_pkg::side_t                   side_in,
	output logic                              out_valid,
	output logic [chji_pkg::S_W-1:0]          quot,
	output chji_pkg::side_t                   side_out
);
	logic                          valid_s [chji_pkg::DIV_STEPS];
	logic [chji_pkg::DATA_W-1:0]   rem_s   [chji_pkg::DIV_STEPS];
	logic [chji_pkg::S_W-1:0]      low_s   [chji_pkg::DIV_STEPS];
	logic [chji_pkg::S_W-1:0]      quot_s  [chji_pkg::DIV_STEPS];
	logic [chji_pkg::DATA_W-1:0]   dur_s   [chji_pkg::DIV_STEPS];
	chji_pkg::side_t               side_s  [chji_pkg::DIV_STEPS];

	for (genvar k = 0; k < chji_pkg::DIV_STEPS; k++) begin : g_step
		logic                        valid_prev;
		logic [chji_pkg::DATA_W-1:0] rem_prev;
		logic [chji_pkg::S_W-1:0]    low_prev;
		logic [chji_pkg::S_W-1:0]    quot_prev;
		logic [chji_pkg::DATA_W-1:0] dur_prev;
		chji_pkg::side_t             side_prev;
		logic [chji_pkg::DATA_W:0]   trial;
		logic                        fits;

		if (k == 0) begin : g_first
			// The top bits of the numerator are already below the divisor.
			assign valid_prev = in_valid;
			assign rem_prev   = numer[chji_pkg::NUM_W-1:chji_pkg::S_W];
			assign low_prev   = numer[chji_pkg::S_W-1:0];
			assign quot_prev  = '0;
			assign dur_prev   = divisor;
			assign side_prev  = side_in;
		end else begin : g_next
			assign valid_prev = valid_s[k-1];
			assign rem_prev   = rem_s[k-1];
			assign low_prev   = low_s[k-1];
			assign quot_prev  = quot_s[k-1];
			assign dur_prev   = dur_s[k-1];
			assign side_prev  = side_s[k-1];
		end

		assign trial = {rem_prev, low_prev[chji_pkg::S_W-1]};
		assign fits  = trial >= {1'b0, dur_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_prev;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= fits ? chji_pkg::DATA_W'(trial - {1'b0, dur_prev})
			                  : trial[chji_pkg::DATA_W-1:0];
			low_s[k]  <= {low_prev[chji_pkg::S_W-2:0], 1'b0};
			quot_s[k] <= {quot_prev[chji_pkg::S_W-2:0], fits};
			dur_s[k]  <= dur_prev;
			side_s[k] <= side_prev;
		end
	end

	assign out_valid = valid_s[chji_pkg::DIV_STEPS-1];
	assign quot      = quot_s[chji_pkg::DIV_STEPS-1];
	assign side_out  = side_s[chji_pkg::DIV_STEPS-1];

	`CHJI_ASSERT_IMP(a_div_latency, out_valid, $past(in_valid, chji_pkg::DIV_STEPS),
		"divider produced an item that never entered")
	`CHJI_ASSERT_IMP(a_div_rem, out_valid && (dur_s[chji_pkg::DIV_STEPS-1] != '0),
		rem_s[chji_pkg::DIV_STEPS-1] < dur_s[chji_pkg::DIV_STEPS-1],
		"divider remainder not below divisor")
	`CHJI_ASSERT_IMP(a_div_quot, out_valid && !side_out.zero_dur, quot <= chji_pkg::S_ONE,
		"normalised time above one")
endmodule

[rtl/core/chji_horner.sv]
`timescale 1ns / 1ps
// One Horner step: acc * s / 2^32 rounded away from zero, plus a coefficient.
module chji_horner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  chji_pkg::coef_sel_t               sel,
	input  logic signed [chji_pkg::ACC_W-1:0] acc_in,
	input  logic [chji_pkg::S_W-1:0]          s_in,
	input  chji_pkg::side_t                   side_in,
	output logic                              out_valid,
	output logic signed [chji_pkg::ACC_W-1:0] acc_out,
	output logic [chji_pkg::S_W-1:0]          s_out,
	output chji_pkg::side_t                   side_out
);
	logic                              valid_s1, valid_s2, valid_s3, valid_s4;
	logic                              neg_s1, neg_s2, neg_s3;
	logic [chji_pkg::MAG_W-1:0]        mag_s1;
	logic [chji_pkg::HI_PROD_W-1:0]    hi_prod_s2;
	logic [chji_pkg::LO_PROD_W-1:0]    lo_prod_s2;
	logic [chji_pkg::MAG_W-1:0]        r_s3;
	logic signed [chji_pkg::ACC_W-1:0] acc_s4;
	logic [chji_pkg::S_W-1:0]          s_s1, s_s2, s_s3, s_s4;
	chji_pkg::side_t                   side_s1, side_s2, side_s3, side_s4;
	logic signed [chji_pkg::ACC_W-1:0] addend;
	logic signed [chji_pkg::ACC_W-1:0] r_ext;
	logic [chji_pkg::LO_PROD_W-1:0]    lo_rnd;

	always_comb begin
		unique case (sel)
			chji_pkg::SEL_C2: addend = side_s3.c2;
			chji_pkg::SEL_A:  addend = side_s3.a;
			chji_pkg::SEL_P0: addend = chji_pkg::ACC_W'(side_s3.p0);
			default:          addend = '0;
		endcase
	end

	assign lo_rnd = (lo_prod_s2 + chji_pkg::ROUND_S) >> chji_pkg::FRAC_S;
	assign r_ext  = signed'(chji_pkg::ACC_W'(r_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1     <= acc_in[chji_pkg::ACC_W-1];
		mag_s1     <= chji_pkg::MAG_W'(acc_in[chji_pkg::ACC_W-1] ? -acc_in : acc_in);
		s_s1       <= s_in;
		side_s1    <= side_in;
		hi_prod_s2 <= chji_pkg::HI_PROD_W'(mag_s1[chji_pkg::MAG_W-1:chji_pkg::FRAC_S])
		              * chji_pkg::HI_PROD_W'(s_s1);
		lo_prod_s2 <= chji_pkg::LO_PROD_W'(mag_s1[chji_pkg::FRAC_S-1:0])
		              * chji_pkg::LO_PROD_W'(s_s1);
		neg_s2     <= neg_s1;
		s_s2       <= s_s1;
		side_s2    <= side_s1;
		r_s3       <= chji_pkg::MAG_W'(hi_prod_s2) + chji_pkg::MAG_W'(lo_rnd);
		neg_s3     <= neg_s2;
		s_s3       <= s_s2;
		side_s3    <= side_s2;
		acc_s4     <= neg_s3 ? (addend - r_ext) : (addend + r_ext);
		s_s4       <= s_s3;
		side_s4    <= side_s3;
	end

	assign out_valid = valid_s4;
	assign acc_out   = acc_s4;
	assign s_out     = s_s4;
	assign side_out  = side_s4;
endmodule

[verif/cubic_hermite_joint_interpolator_unit_tb.sv]
`timescale 1ns / 1ps
module cubic_hermite_joint_interpolator_unit_tb;
	// Sampling happens at the rising edge and drives use nonblocking assignments, so
	// nothing depends on the ordering of events inside a time step.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 750;
	localparam int N_DIRECTED = 16;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	chji_pkg::in_item_t item;
	logic done;
	chji_pkg::out_item_t result;

	// One directed row: the item, and an optional typed-in expectation.
	typedef struct {
		chji_pkg::in_item_t  stim;
		bit                  has_fixed;
		chji_pkg::out_item_t fixed;
	} joint_row_t;

	joint_row_t joint_rows [N_DIRECTED];
	chji_pkg::out_item_t pending_positions [$];
	int mismatch_count;
	int cycle_count;
	bit stim_done;

	cubic_hermite_joint_interpolator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Magnitude times duration, rescaled by 2^-F with ties away from zero.
	function automatic longint scale_velocity(logic [31:0] dur, logic signed [31:0] vel);
		logic [63:0] mag;
		logic [63:0] prod;
		mag = (vel < 0) ? 64'(-longint'(vel)) : 64'(vel);
		prod = 64'(dur) * mag;
		prod = (prod + (64'd1 << (chji_pkg::FRAC_BITS - 1))) >> chji_pkg::FRAC_BITS;
		return (vel < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// acc * s / 2^32 with ties away from zero; s is at most 2^32.
	function automatic longint horner_scale(longint acc, logic [63:0] s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = (acc < 0) ? 64'(-acc) : 64'(acc);
		r = (mag >> 32) * s + (((mag & 64'hFFFF_FFFF) * s + 64'h8000_0000) >> 32);
		return (acc < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic chji_pkg::out_item_t interpolate_position(chji_pkg::in_item_t it);
		chji_pkg::out_item_t res;
		logic [63:0] t;
		logic [63:0] dur;
		logic [63:0] s;
		longint a;
		longint b;
		longint dp;
		longint c2;
		longint c3;
		longint acc;
		t = 64'(it.elapsed_time);
		dur = 64'(it.segment_duration);
		res.status = chji_pkg::ST_OK;
		if (dur == 0) begin
			res.position = it.start_position;
			res.status = chji_pkg::ST_ZERO_DUR;
			return res;
		end
		// Time past the end of the segment holds the end point; this is not an error.
		if (t > dur) begin
			t = dur;
		end
		s = ((t << 32) + (dur >> 1)) / dur;
		a = scale_velocity(it.segment_duration, it.start_velocity);
		b = scale_velocity(it.segment_duration, it.end_velocity);
		dp = longint'(it.end_position) - longint'(it.start_position);
		c2 = 3 * dp - 2 * a - b;
		c3 = a + b - 2 * dp;
		acc = horner_scale(c3, s) + c2;
		acc = horner_scale(acc, s) + a;
		acc = horner_scale(acc, s) + longint'(it.start_position);
		if (acc > longint'(chji_pkg::POS_MAX)) begin
			res.position = chji_pkg::POS_MAX;
			res.status = chji_pkg::ST_SAT;
		end else if (acc < longint'(chji_pkg::NEG_MIN)) begin
			res.position = chji_pkg::NEG_MIN;
			res.status = chji_pkg::ST_SAT;
		end else begin
			res.position = acc[31:0];
		end
		return res;
	endfunction

	function automatic chji_pkg::in_item_t make_segment(logic [31:0] t, logic [31:0] dur,
			logic [31:0] p0, logic [31:0] p1, logic [31:0] v0, logic [31:0] v1);
		chji_pkg::in_item_t it;
		it.elapsed_time = t;
		it.segment_duration = dur;
		it.start_position = p0;
		it.end_position = p1;
		it.start_velocity = v0;
		it.end_velocity = v1;
		return it;
	endfunction

	// Mostly plausible motion segments with random content, plus zero-duration, near-rail and raw noise items.
	function automatic chji_pkg::in_item_t random_segment();
		chji_pkg::in_item_t it;
		logic [31:0] dur;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			dur = $urandom_range(1, 32'h0008_0000);
			it = make_segment($urandom_range(0, dur + dur / 8), dur,
				32'($signed($urandom_range(0, 32'h0006_4000)) - 32'sh0003_2000),
				32'($signed($urandom_range(0, 32'h0006_4000)) - 32'sh0003_2000),
				32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
				32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
		end else if (pick == 6) begin
			it = make_segment($urandom, 32'd0, $urandom, $urandom, $urandom, $urandom);
		end else if (pick == 7) begin
			// Start positions with bits 30:28 set, near the positive rail when the sign is clear, provoke saturation.
			dur = $urandom_range(1, 32'h0010_0000);
			it = make_segment($urandom_range(0, dur), dur,
				32'h7000_0000 ^ ($urandom & 32'h8FFF_FFFF), $urandom, $urandom, $urandom);
		end else begin
			it = make_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		return it;
	endfunction

	initial begin
		joint_rows[0] = '{make_segment(0, 0, 32'h1234_5678, 0, 0, 0), 1,
			'{32'h1234_5678, chji_pkg::ST_ZERO_DUR}};
		joint_rows[1] = '{make_segment(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000), 1, '{32'h8000_0000, chji_pkg::ST_ZERO_DUR}};
		joint_rows[2] = '{make_segment(0, 32'h0001_0000, 32'h0002_0000, 32'h0005_0000,
			0, 0), 1, '{32'h0002_0000, chji_pkg::ST_OK}};
		joint_rows[3] = '{make_segment(32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
			32'h0005_0000, 0, 0), 1, '{32'h0005_0000, chji_pkg::ST_OK}};
		// Elapsed time beyond the segment end clamps to the end position.
		joint_rows[4] = '{make_segment(32'hFFFF_FFFF, 32'h0001_0000, 0, 32'hFFFF_0000,
			0, 0), 1, '{32'hFFFF_0000, chji_pkg::ST_OK}};
		joint_rows[5] = '{make_segment(32'h0000_8000, 32'h0001_0000, 0, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[6] = '{make_segment(32'h0000_8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[7] = '{make_segment(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[8] = '{make_segment(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 0), 1, '{32'h7FFF_FFFF, chji_pkg::ST_OK}};
		joint_rows[9] = '{make_segment(32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 0), 1, '{32'h8000_0000, chji_pkg::ST_OK}};
		joint_rows[10] = '{make_segment(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_0000,
			32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[11] = '{make_segment(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[12] = '{make_segment(32'h0003_0000, 32'h0006_0000, 32'hFFFE_0000,
			32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[13] = '{make_segment(32'h0000_0001, 32'h0000_0003, 32'h0000_0001,
			32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0001), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[14] = '{make_segment(32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0, '{0, chji_pkg::ST_OK}};
		joint_rows[15] = '{make_segment(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 0, '{0, chji_pkg::ST_OK}};
	end

	// Offer one item and hold it until the block accepts it.
	task automatic send_joint(chji_pkg::in_item_t it, bit has_fixed,
			chji_pkg::out_item_t fixed);
		chji_pkg::out_item_t want_item;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		want_item = has_fixed ? fixed : interpolate_position(it);
		pending_positions = {pending_positions, want_item};
	endtask

	task automatic lower_start();
		start <= 1'b0;
		item <= $urandom ? {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom} : '0;
	endtask

	task automatic idle_gap();
		int gap;
		gap = $urandom_range(1, 6);
		lower_start();
		repeat (gap) @(posedge clk);
	endtask

	initial begin
		int burst;
		int sent;
		stim_done = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_joint(joint_rows[i].stim, joint_rows[i].has_fixed, joint_rows[i].fixed);
			if ($urandom_range(0, 2) == 0) begin
				idle_gap();
			end
		end

		// The sender waits here until the pipeline has drained completely.
		lower_start();
		while (pending_positions.size() != 0) begin
			@(posedge clk);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// Some bursts run long to keep back-to-back acceptance covered.
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				send_joint(random_segment(), 0, '{0, chji_pkg::ST_OK});
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				idle_gap();
			end
		end
		lower_start();
		stim_done = 1;
	end

	// Results arrive as single-cycle strobes and are checked in order.
	always @(posedge clk) begin
		chji_pkg::out_item_t want;
		if (arst_n && done) begin
			if (pending_positions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: position %h status %0d",
						result.position, result.status);
				end
			end else begin
				want = pending_positions.pop_front();
				if (result.position !== want.position || result.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("position exp %h got %h, status exp %0d got %0d",
							want.position, result.position, want.status, result.status);
					end
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		wait (stim_done);
		while (pending_positions.size() != 0 && cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (mismatch_count == 0) begin
				$display("No mismatches found");
			end else begin
				$display("Mismatches found");
			end
		end
		$finish;
	end

	// Overall guard against a hang anywhere in the run.
	initial begin
		repeat (CYCLE_LIMIT * 2) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/chji_pkg.sv
rtl/core/chji_div.sv
rtl/core/chji_horner.sv
rtl/core/cubic_hermite_joint_interpolator_unit.sv
verif/cubic_hermite_joint_interpolator_unit_tb.sv
